[sv/cbid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbid_pkg
// Shared types, widths and codes of the character line insert/delete unit.
// ----------------------------------------------------------------------------
package cbid_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int POS_W       = 9;
  localparam int CHAR_W      = 8;
  localparam int REC_CHAR_W  = 7;
  localparam int STATUS_W    = 3;
  localparam int LEN_W       = 9;

  localparam logic [REC_CHAR_W-1:0] SPACE_CODE   = 7'd32;
  localparam logic [CHAR_W-1:0]     LOWEST_CODE  = 8'd32;
  localparam logic [REC_CHAR_W-1:0] ZERO_CODE    = 7'd0;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE         = 3'd0,
    ST_BAD_POSITION = 3'd1,
    ST_NOTHING      = 3'd2,
    ST_BAD_CHAR     = 3'd3,
    ST_FULL         = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_INS_SHIFT,
    SQ_PUT,
    SQ_DEL_CHECK,
    SQ_DEL_SHIFT,
    SQ_REPORT
  } seq_state_t;

  typedef struct packed {
    logic               start;
    op_t                op;
    logic [POS_W-1:0]   pos;
    logic [CHAR_W-1:0]  ch;
  } cbid_cmd_t;

  typedef struct packed {
    logic               done;
    status_t            status;
    logic [LEN_W-1:0]   length;
  } cbid_rsp_t;

endpackage
`default_nettype wire

[sv/cbid_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbid_in_if
// Request channel: one edit request per beat.
// ----------------------------------------------------------------------------
interface cbid_in_if import cbid_pkg::*; ();
  logic              valid;
  logic              ready;
  op_t               operation;
  logic [POS_W-1:0]  position;
  logic [CHAR_W-1:0] character;

  modport source (output valid, output operation, output position, output character,
                  input ready);
  modport sink   (input valid, input operation, input position, input character,
                  output ready);
endinterface
`default_nettype wire

[sv/cbid_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbid_out_if
// Edit record channel: one record per beat.
// ----------------------------------------------------------------------------
interface cbid_out_if import cbid_pkg::*; ();
  logic                  valid;
  logic                  ready;
  status_t               status;
  op_t                   event_kind;
  logic [POS_W-1:0]      record_position;
  logic [REC_CHAR_W-1:0] record_character;
  logic [LEN_W-1:0]      line_length;

  modport source (output valid, output status, output event_kind, output record_position,
                  output record_character, output line_length, input ready);
  modport sink   (input valid, input status, input event_kind, input record_position,
                  input record_character, input line_length, output ready);
endinterface
`default_nettype wire

[sv/cbid_edit_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbid_edit_seq
// Line memory, length counter and the sequencer that checks a request and
// shifts the tail through the memory one entry per cycle.
// ----------------------------------------------------------------------------
module cbid_edit_seq import cbid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cbid_cmd_t cmd,
  output logic           idle,
  input  wire logic      rsp_ready,
  output cbid_rsp_t      rsp
);

  localparam int AW   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [REC_CHAR_W-1:0] mem [CAPACITY];
  logic [REC_CHAR_W-1:0] rd_data_r;

  seq_state_t            state_r, state_nxt, pre_state;
  status_t               status_r, status_nxt, pre_status;
  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         j_r, j_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [REC_CHAR_W-1:0] ch_r, ch_nxt;

  logic                  rd_en, wr_en;
  logic [AW-1:0]         rd_addr, wr_addr;
  logic [REC_CHAR_W-1:0] wr_data;

  logic [CMPW-1:0]       cmd_pos_w, cnt_w, cap_w;
  logic [AW-1:0]         last_addr;
  logic                  last_ins, last_del, del_space, del_tail_empty, line_full;

  assign cmd_pos_w      = CMPW'(cmd.pos);
  assign cnt_w          = CMPW'(count_r);
  assign cap_w          = CMPW'(CAPACITY);
  assign line_full      = (cnt_w == cap_w);
  assign last_addr      = AW'(count_r - CW'(1));
  assign last_ins       = (j_r == pos_r);
  assign last_del       = (j_r == last_addr);
  assign del_space      = (rd_data_r == SPACE_CODE);
  assign del_tail_empty = (pos_r == last_addr);

  // Request checks, in the order the statuses take priority.
  always_comb begin
    pre_status = ST_DONE;
    pre_state  = SQ_REPORT;
    unique case (cmd.op)
      OP_INSERT: begin
        if (cmd_pos_w > cnt_w) begin
          pre_status = ST_BAD_POSITION;
        end else if (cmd.ch < LOWEST_CODE || cmd.ch[CHAR_W-1]) begin
          pre_status = ST_BAD_CHAR;
        end else if (line_full) begin
          pre_status = ST_FULL;
        end else if (cmd_pos_w == cnt_w) begin
          pre_state = SQ_PUT;
        end else begin
          pre_state = SQ_INS_SHIFT;
        end
      end
      OP_DELETE: begin
        if (count_r == '0) begin
          pre_status = ST_NOTHING;
        end else if (cmd_pos_w >= cap_w) begin
          pre_status = ST_BAD_POSITION;
        end else if (cmd_pos_w >= cnt_w) begin
          pre_status = ST_NOTHING;
        end else begin
          pre_state = SQ_DEL_CHECK;
        end
      end
      default: begin
        pre_status = ST_DONE;
        pre_state  = SQ_REPORT;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SQ_IDLE:      if (cmd.start) state_nxt = pre_state;
      SQ_INS_SHIFT: if (last_ins) state_nxt = SQ_PUT;
      SQ_PUT:       state_nxt = SQ_REPORT;
      SQ_DEL_CHECK: begin
        if (del_space || del_tail_empty) state_nxt = SQ_REPORT;
        else state_nxt = SQ_DEL_SHIFT;
      end
      SQ_DEL_SHIFT: if (last_del) state_nxt = SQ_REPORT;
      SQ_REPORT:    if (rsp_ready) state_nxt = SQ_IDLE;
      default:      state_nxt = SQ_IDLE;
    endcase
  end

  // Memory control and datapath
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = j_r;
    wr_en      = 1'b0;
    wr_addr    = pos_r;
    wr_data    = ch_r;
    count_nxt  = count_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    ch_nxt     = ch_r;
    status_nxt = status_r;
    unique case (state_r)
      SQ_IDLE: begin
        if (cmd.start) begin
          pos_nxt    = AW'(cmd.pos);
          ch_nxt     = cmd.ch[REC_CHAR_W-1:0];
          status_nxt = pre_status;
          if (pre_state == SQ_INS_SHIFT) begin
            rd_en   = 1'b1;
            rd_addr = last_addr;
            j_nxt   = last_addr;
          end else if (pre_state == SQ_DEL_CHECK) begin
            rd_en   = 1'b1;
            rd_addr = AW'(cmd.pos);
          end
        end
      end
      SQ_INS_SHIFT: begin
        // entry j moves to j+1; the next read is j-1
        wr_en   = 1'b1;
        wr_addr = j_r + AW'(1);
        wr_data = rd_data_r;
        if (!last_ins) begin
          rd_en   = 1'b1;
          rd_addr = j_r - AW'(1);
          j_nxt   = j_r - AW'(1);
        end
      end
      SQ_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = pos_r;
        wr_data   = ch_r;
        count_nxt = count_r + CW'(1);
      end
      SQ_DEL_CHECK: begin
        if (del_space) begin
          status_nxt = ST_NOTHING;
        end else if (del_tail_empty) begin
          count_nxt = count_r - CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = pos_r + AW'(1);
          j_nxt   = pos_r + AW'(1);
        end
      end
      SQ_DEL_SHIFT: begin
        // entry j moves to j-1; the next read is j+1
        wr_en   = 1'b1;
        wr_addr = j_r - AW'(1);
        wr_data = rd_data_r;
        if (last_del) begin
          count_nxt = count_r - CW'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_r + AW'(1);
          j_nxt   = j_r + AW'(1);
        end
      end
      SQ_REPORT: begin
        status_nxt = status_r;
      end
      default: begin
        status_nxt = status_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r      <= j_nxt;
    pos_r    <= pos_nxt;
    ch_r     <= ch_nxt;
    status_r <= status_nxt;
  end

  // Entries are always written before they are read, so no clearing pass.
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  assign idle       = (state_r == SQ_IDLE);
  assign rsp.done   = (state_r == SQ_REPORT);
  assign rsp.status = status_r;
  assign rsp.length = LEN_W'(count_r);

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write hit the same entry");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_w <= cap_w)
    else $error("line length above capacity");

  a_ins_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_INS_SHIFT) |-> (j_r >= pos_r))
    else $error("insert shift ran below the edit position");

  a_del_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SQ_DEL_SHIFT) |-> (j_r > pos_r && CW'(j_r) < count_r))
    else $error("delete shift cursor outside the tail");

endmodule
`default_nettype wire

[sv/char_buffer_insert_delete_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_buffer_insert_delete_unit
// Fixed-capacity line of printable characters with insert and delete,
// one edit record per request.
// ----------------------------------------------------------------------------
// channel   dir  handshake     payload
// in_chan   in   valid/ready   operation, position, character
// out_chan  out  valid/ready   status, event_kind, record_position,
//                              record_character, line_length
//
// A request rejected by the checks at accept goes straight to its record;
// a delete reads its entry and reports at once if that is a space; an insert
// shifts the tail up, then puts the character; a done delete shifts any tail
// down, through the single-port-pair line memory, one entry per cycle.
// The next request is taken the cycle after the record moves to the output
// register, even while that record still waits.
// Reset clears the length and control; memory needs no clearing pass.
// A stalled output holds the sequencer in its report step.
// ----------------------------------------------------------------------------
module char_buffer_insert_delete_unit import cbid_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbid_in_if.sink     in_chan,
  cbid_out_if.source  out_chan
);

  cbid_cmd_t             cmd;
  cbid_rsp_t             rsp;
  logic                  eng_idle, rsp_ready, in_fire;

  op_t                   op_r;
  logic [POS_W-1:0]      pos_r;
  logic [REC_CHAR_W-1:0] ch_r;

  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  op_t                   out_kind_r;
  logic [POS_W-1:0]      out_pos_r;
  logic [REC_CHAR_W-1:0] out_char_r, rec_char;
  logic [LEN_W-1:0]      out_len_r;

  assign in_chan.ready = eng_idle;
  assign in_fire       = in_chan.valid && eng_idle;

  assign cmd.start = in_fire;
  assign cmd.op    = in_chan.operation;
  assign cmd.pos   = in_chan.position;
  assign cmd.ch    = in_chan.character;

  cbid_edit_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idle      (eng_idle),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= in_chan.operation;
      pos_r <= in_chan.position;
      ch_r  <= in_chan.character[REC_CHAR_W-1:0];
    end
  end

  // Output register: free when empty or being drained this cycle.
  assign rsp_ready = !out_valid_r || out_chan.ready;

  always_comb begin
    if (op_r == OP_DELETE) rec_char = SPACE_CODE;
    else if (rsp.status == ST_DONE) rec_char = ch_r;
    else rec_char = ZERO_CODE;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.done && rsp_ready) out_valid_nxt = 1'b1;
    else if (out_chan.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp.done && rsp_ready) begin
      out_status_r <= rsp.status;
      out_kind_r   <= op_r;
      out_pos_r    <= pos_r;
      out_char_r   <= rec_char;
      out_len_r    <= rsp.length;
    end
  end

  assign out_chan.valid            = out_valid_r;
  assign out_chan.status           = out_status_r;
  assign out_chan.event_kind       = out_kind_r;
  assign out_chan.record_position  = out_pos_r;
  assign out_chan.record_character = out_char_r;
  assign out_chan.line_length      = out_len_r;

endmodule
`default_nettype wire
